### rtl/pbe_pkg.sv
`timescale 1ns / 1ps
// Package for the polynomial basis evaluator: payload structs, cell control,
// fixed-point constants and selector codes. No dependencies.
package pbe_pkg;

  localparam int RES_W      = 52;
  localparam int X_W        = 32;
  localparam int LEFT_W     = 55;
  localparam int FRAC_BITS  = 30;
  localparam int MAX_DEGREE = 31;

  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};
  localparam logic signed [RES_W-1:0] ONE_Q   = RES_W'(1) << FRAC_BITS;

  localparam logic [1:0] FUNC_VALUE = 2'd0;
  localparam logic [1:0] FUNC_D1    = 2'd1;
  localparam logic [1:0] FUNC_D2    = 2'd2;

  localparam logic BASIS_MONO = 1'b0;
  localparam logic BASIS_CHEB = 1'b1;

  typedef struct packed {
    logic signed [X_W-1:0] x_value;
    logic [4:0]            degree;
    logic [1:0]            func;
  } in_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result_value;
    logic                    saturated;
  } out_t;

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic cheb;
  } cell_ctrl_t;

endpackage

### rtl/pbe_cell.sv
`timescale 1ns / 1ps
// One recurrence cell: holds the current and previous term of one sequence and
// forms the next term with a multiply by x split into two half products. Depends on pbe_pkg.
module pbe_cell (
  input  logic                          clk_i,
  input  pbe_pkg::cell_ctrl_t           ctrl_i,
  input  logic [pbe_pkg::X_W-1:0]       x_mag_i,
  input  logic                          x_neg_i,
  input  logic signed [pbe_pkg::RES_W-1:0]  init_cur_i,
  input  logic signed [pbe_pkg::RES_W-1:0]  init_prev_i,
  input  logic signed [pbe_pkg::LEFT_W-1:0] left_i,
  output logic signed [pbe_pkg::RES_W-1:0]  cur_o,
  output logic                          sat_o
);
  import pbe_pkg::*;

  localparam int PP_W   = 58;
  localparam int PROD_W = 84;
  localparam int SUM_W  = 56;
  localparam logic [PROD_W-1:0] RND_CHEB = PROD_W'(1) << (FRAC_BITS - 2);
  localparam logic [PROD_W-1:0] RND_MONO = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [PROD_W-1:0] LIM_POS  = PROD_W'(RES_MAX);
  localparam logic [PROD_W-1:0] LIM_NEG  = PROD_W'(RES_MAX) + PROD_W'(1);
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(RES_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(RES_MIN);

  logic signed [RES_W-1:0] cur_q, cur_d, prev_q, prev_d, new_val;
  logic [PP_W-1:0]         pp_lo_q, pp_lo_d, pp_hi;
  logic                    b_neg, p_neg, mul_ovf, sum_ovf;
  logic [RES_W-1:0]        b_mag, q_mag;
  logic [PROD_W-1:0]       prod, rnd, quo, lim;
  logic signed [RES_W:0]   m_val;
  logic signed [SUM_W-1:0] sum;

  always_comb begin
    b_neg   = cur_q[RES_W-1];
    b_mag   = b_neg ? RES_W'(-cur_q) : RES_W'(cur_q);
    p_neg   = x_neg_i ^ b_neg;
    pp_lo_d = PP_W'(x_mag_i) * PP_W'(b_mag[25:0]);
    pp_hi   = PP_W'(x_mag_i) * PP_W'(b_mag[RES_W-1:26]);
    prod    = {pp_hi, 26'b0} + PROD_W'(pp_lo_q);
    rnd     = prod + (ctrl_i.cheb ? RND_CHEB : RND_MONO);
    quo     = ctrl_i.cheb ? (rnd >> (FRAC_BITS - 1)) : (rnd >> FRAC_BITS);
    lim     = p_neg ? LIM_NEG : LIM_POS;
    mul_ovf = quo > lim;
    q_mag   = mul_ovf ? lim[RES_W-1:0] : quo[RES_W-1:0];
    m_val   = p_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    if (ctrl_i.cheb) begin
      sum = SUM_W'(left_i) + SUM_W'(m_val) - SUM_W'(prev_q);
    end else begin
      sum = SUM_W'(m_val);
    end
    sum_ovf = (sum > SUM_MAX) || (sum < SUM_MIN);
    if (sum > SUM_MAX) begin
      new_val = RES_MAX;
    end else if (sum < SUM_MIN) begin
      new_val = RES_MIN;
    end else begin
      new_val = $signed(sum[RES_W-1:0]);
    end
    sat_o = ctrl_i.mul_hi & (mul_ovf | sum_ovf);

    cur_d  = cur_q;
    prev_d = prev_q;
    if (ctrl_i.load) begin
      cur_d  = init_cur_i;
      prev_d = init_prev_i;
    end else if (ctrl_i.mul_hi) begin
      cur_d  = new_val;
      prev_d = cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    prev_q <= prev_d;
    if (ctrl_i.mul_lo) begin
      pp_lo_q <= pp_lo_d;
    end
  end

  assign cur_o = cur_q;

endmodule

### rtl/poly_basis_eval_with_derivs.sv
`timescale 1ns / 1ps
// Top level of the polynomial basis evaluator: sequencer, configuration
// register and a row of three pbe_cell instances. Depends on pbe_pkg, pbe_cell.

// An item is taken when start_i is high and busy_o is low. Each recurrence
// step does the 32 x 52 bit multiply in every cell as two half products, in
// states S_LO and S_HI. With n steps (degree - 1 for Chebyshev at degree
// two or more, degree minus derivative order for monomials, otherwise zero) the
// result beat appears after the n steps and state S_FIN, and busy_o drops in
// that same cycle, so a new item is taken only once the last result is out. The
// result is on res_o for one cycle under res_valid_o; there is no way to hold
// it, so the receiver must take it then. Write basis_kind on the cfg channel
// only while busy_o is low and no result is pending.
module poly_basis_eval_with_derivs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  pbe_pkg::in_t  in_i,
  output logic          res_valid_o,
  output pbe_pkg::out_t res_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_data_i
);
  import pbe_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_LO, S_HI, S_FIN} state_e;

  localparam int FPROD_W = 63;
  localparam logic signed [FPROD_W-1:0] F_MAX = FPROD_W'(RES_MAX);
  localparam logic signed [FPROD_W-1:0] F_MIN = FPROD_W'(RES_MIN);

  state_e state_q, state_d;
  logic [4:0] steps_q, steps_d, k;
  logic [1:0] f_q, f_d, f_in;
  logic [9:0] factor_q, factor_d;
  logic basis_q, basis_d, cheb_q, cheb_d, zero_q, zero_d, sat_q, sat_d;
  logic res_valid_q, res_valid_d, accept;
  out_t res_q, res_d;

  cell_ctrl_t ctrl;
  logic [X_W-1:0] x_mag_q, x_mag_d;
  logic x_neg_q, x_neg_d;
  logic signed [RES_W-1:0] xs;
  logic signed [RES_W-1:0] t_init_cur, t_init_prev, d_init_cur;
  logic signed [RES_W-1:0] t_cur, d_cur, s_cur, sel_val;
  logic signed [LEFT_W-1:0] d_left, s_left;
  logic t_sat, d_sat, s_sat;
  logic signed [FPROD_W-1:0] fprod;

  assign accept      = start_i & (state_q == S_IDLE);
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    k    = (int'(in_i.degree) > MAX_DEGREE) ? 5'(MAX_DEGREE) : in_i.degree;
    f_in = (in_i.func == FUNC_VALUE || in_i.func == FUNC_D1) ? in_i.func : FUNC_D2;
    xs   = RES_W'(in_i.x_value);

    t_init_cur  = ONE_Q;
    t_init_prev = '0;
    d_init_cur  = '0;
    if (basis_q == BASIS_CHEB) begin
      t_init_prev = ONE_Q;
      if (k != 5'd0) begin
        t_init_cur = xs;
        d_init_cur = ONE_Q;
      end
    end

    ctrl.load   = accept;
    ctrl.mul_lo = (state_q == S_LO);
    ctrl.mul_hi = (state_q == S_HI);
    ctrl.cheb   = cheb_q;

    d_left = {{2{t_cur[RES_W-1]}}, t_cur, 1'b0};
    s_left = {d_cur[RES_W-1], d_cur, 2'b0};

    fprod = FPROD_W'($signed({1'b0, factor_q})) * FPROD_W'(t_cur);

    unique case (f_q)
      FUNC_VALUE: sel_val = t_cur;
      FUNC_D1:    sel_val = d_cur;
      default:    sel_val = s_cur;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    steps_d     = steps_q;
    f_d         = f_q;
    factor_d    = factor_q;
    basis_d     = basis_q;
    cheb_d      = cheb_q;
    zero_d      = zero_q;
    sat_d       = sat_q;
    x_mag_d     = x_mag_q;
    x_neg_d     = x_neg_q;
    res_valid_d = 1'b0;
    res_d       = res_q;

    if (cfg_valid_i && cfg_ready_o) begin
      basis_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          f_d     = f_in;
          cheb_d  = (basis_q == BASIS_CHEB);
          sat_d   = 1'b0;
          x_neg_d = in_i.x_value[X_W-1];
          x_mag_d = in_i.x_value[X_W-1] ? X_W'(-in_i.x_value) : X_W'(in_i.x_value);
          zero_d  = 1'b0;
          if (basis_q == BASIS_CHEB) begin
            steps_d = (k >= 5'd2) ? k - 5'd1 : 5'd0;
          end else begin
            zero_d  = k < 5'(f_in);
            steps_d = (k >= 5'(f_in)) ? k - 5'(f_in) : 5'd0;
          end
          unique case (f_in)
            FUNC_VALUE: factor_d = 10'd1;
            FUNC_D1:    factor_d = 10'(k);
            default:    factor_d = (k >= 5'd2) ? 10'(k) * 10'(k - 5'd1) : 10'd0;
          endcase
          state_d = (steps_d != 5'd0) ? S_LO : S_FIN;
        end
      end
      S_LO: begin
        state_d = S_HI;
      end
      S_HI: begin
        sat_d   = sat_q | t_sat | (cheb_q & (d_sat | s_sat));
        steps_d = steps_q - 5'd1;
        state_d = (steps_q == 5'd1) ? S_FIN : S_LO;
      end
      S_FIN: begin
        res_valid_d = 1'b1;
        if (cheb_q) begin
          res_d.result_value = sel_val;
          res_d.saturated    = sat_q;
        end else if (zero_q) begin
          res_d.result_value = '0;
          res_d.saturated    = sat_q;
        end else if (fprod > F_MAX) begin
          res_d.result_value = RES_MAX;
          res_d.saturated    = 1'b1;
        end else if (fprod < F_MIN) begin
          res_d.result_value = RES_MIN;
          res_d.saturated    = 1'b1;
        end else begin
          res_d.result_value = $signed(fprod[RES_W-1:0]);
          res_d.saturated    = sat_q;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      basis_q     <= BASIS_CHEB;
      res_valid_q <= 1'b0;
      steps_q     <= '0;
    end else begin
      state_q     <= state_d;
      basis_q     <= basis_d;
      res_valid_q <= res_valid_d;
      steps_q     <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q      <= f_d;
    factor_q <= factor_d;
    cheb_q   <= cheb_d;
    zero_q   <= zero_d;
    sat_q    <= sat_d;
    x_mag_q  <= x_mag_d;
    x_neg_q  <= x_neg_d;
    res_q    <= res_d;
  end

  pbe_cell u_cell_t (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .x_mag_i     (accept ? x_mag_d : x_mag_q),
    .x_neg_i     (accept ? x_neg_d : x_neg_q),
    .init_cur_i  (t_init_cur),
    .init_prev_i (t_init_prev),
    .left_i      ('0),
    .cur_o       (t_cur),
    .sat_o       (t_sat)
  );

  pbe_cell u_cell_d (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .x_mag_i     (x_mag_q),
    .x_neg_i     (x_neg_q),
    .init_cur_i  (d_init_cur),
    .init_prev_i ('0),
    .left_i      (d_left),
    .cur_o       (d_cur),
    .sat_o       (d_sat)
  );

  pbe_cell u_cell_s (
    .clk_i       (clk_i),
    .ctrl_i      (ctrl),
    .x_mag_i     (x_mag_q),
    .x_neg_i     (x_neg_q),
    .init_cur_i  ('0),
    .init_prev_i ('0),
    .left_i      (s_left),
    .cur_o       (s_cur),
    .sat_o       (s_sat)
  );

endmodule

### test/tb_poly_basis_eval_with_derivs.sv
`timescale 1ns / 1ps
// Self-checking testbench for poly_basis_eval_with_derivs: corner and random points for
// both bases, each result checked against a fixed-point recurrence predictor.
// Depends on pbe_pkg and the poly_basis_eval_with_derivs RTL.
module tb_poly_basis_eval_with_derivs;
  import pbe_pkg::*;

  localparam int    CYCLE_LIMIT = 1_000_000;
  localparam longint RES_HI     = RES_MAX;
  localparam longint RES_LO     = RES_MIN;
  localparam logic signed [X_W-1:0] X_ONE  = 32'sh4000_0000;
  localparam logic signed [X_W-1:0] X_HALF = 32'sh2000_0000;
  localparam logic signed [X_W-1:0] X_TOP  = 32'sh7FFF_FFFF;
  localparam logic signed [X_W-1:0] X_BOT  = 32'sh8000_0000;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  in_t  in_i;
  logic res_valid_o;
  out_t res_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic cfg_data_i;

  logic basis_sel;
  bit   eval_clipped;
  int   idle_pct;
  int   mismatches = 0;
  int   cycle_count = 0;
  out_t expected_results[$];
  out_t want;

  poly_basis_eval_with_derivs uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_i        (in_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint clip_res(longint v);
    if (v > RES_HI) begin
      eval_clipped = 1'b1;
      return RES_HI;
    end
    if (v < RES_LO) begin
      eval_clipped = 1'b1;
      return RES_LO;
    end
    return v;
  endfunction

  // Exact product scaled down by 2^sh, rounded half away from zero.
  function automatic longint scaled_mul(longint a, longint b, int unsigned sh);
    logic signed [127:0] wa, wb, prod;
    logic [127:0] mag, q, lim;
    bit neg;
    wa = a;
    wb = b;
    prod = wa * wb;
    neg = (a < 0) != (b < 0);
    mag = (prod < 0) ? -prod : prod;
    q = (mag + (128'd1 << (sh - 1))) >> sh;
    lim = neg ? (128'd1 << 51) : (128'd1 << 51) - 1;
    if (q > lim) begin
      eval_clipped = 1'b1;
      q = lim;
    end
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint raise_power(longint x, int n);
    longint p;
    p = ONE_Q;
    for (int i = 0; i < n; i++) p = scaled_mul(x, p, FRAC_BITS);
    return p;
  endfunction

  function automatic longint mono_eval(longint x, int k, logic [1:0] f);
    if (f == FUNC_VALUE) return raise_power(x, k);
    if (f == FUNC_D1) begin
      if (k == 0) return 0;
      return clip_res(longint'(k) * raise_power(x, k - 1));
    end
    if (k < 2) return 0;
    return clip_res(longint'(k * (k - 1)) * raise_power(x, k - 2));
  endfunction

  function automatic longint cheb_eval(longint x, int k, logic [1:0] f);
    longint t0, d0, s0, t1, d1, s1, tn, dn, sn;
    t0 = ONE_Q;
    d0 = 0;
    s0 = 0;
    t1 = x;
    d1 = ONE_Q;
    s1 = 0;
    if (k == 0) begin
      t1 = t0;
      d1 = d0;
      s1 = s0;
    end
    for (int n = 2; n <= k; n++) begin
      tn = clip_res(scaled_mul(x, t1, FRAC_BITS - 1) - t0);
      dn = clip_res(2 * t1 + scaled_mul(x, d1, FRAC_BITS - 1) - d0);
      sn = clip_res(4 * d1 + scaled_mul(x, s1, FRAC_BITS - 1) - s0);
      t0 = t1;
      d0 = d1;
      s0 = s1;
      t1 = tn;
      d1 = dn;
      s1 = sn;
    end
    if (f == FUNC_VALUE) return t1;
    if (f == FUNC_D1) return d1;
    return s1;
  endfunction

  function automatic out_t predict_basis_result(in_t item);
    longint x, v;
    int k;
    logic [1:0] f;
    out_t r;
    eval_clipped = 1'b0;
    x = $signed(item.x_value);
    k = item.degree;
    if (k > MAX_DEGREE) k = MAX_DEGREE;
    f = item.func;
    if (f > FUNC_D2) f = FUNC_D2;
    if (basis_sel == BASIS_CHEB) v = cheb_eval(x, k, f);
    else v = mono_eval(x, k, f);
    r.result_value = v[RES_W-1:0];
    r.saturated = eval_clipped;
    return r;
  endfunction

  function automatic in_t mk_item(logic signed [X_W-1:0] x, int k, logic [1:0] f);
    in_t it;
    it.x_value = x;
    it.degree = k[4:0];
    it.func = f;
    return it;
  endfunction

  function automatic in_t random_item();
    int pick;
    logic signed [X_W-1:0] x;
    pick = $urandom_range(0, 9);
    if (pick < 7) x = X_W'(longint'($urandom_range(0, 32'h8000_0000)) - longint'(X_ONE));
    else if (pick == 7) x = (($urandom_range(0, 1) == 0) ? X_ONE : -X_ONE);
    else if (pick == 8) x = '0;
    else x = $urandom();
    return mk_item(x, $urandom_range(0, 31), 2'($urandom_range(0, 3)));
  endfunction

  task automatic apply_point(in_t item);
    logic [63:0] noise;
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      noise = {$urandom(), $urandom()};
      start_i <= 1'b0;
      in_i <= noise[$bits(in_t)-1:0];
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    in_i <= item;
    do @(posedge clk_i); while (busy_o);
    expected_results.push_back(predict_basis_result(item));
  endtask

  task automatic settle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_basis(logic kind);
    settle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= kind;
    do @(posedge clk_i); while (!cfg_ready_o);
    basis_sel = kind;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_data_i <= $urandom_range(0, 1);
  endtask

  task automatic note_mismatch(string what, out_t exp_v, out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected value %h sat %b, got value %h sat %b", $realtime, what,
               exp_v.result_value, exp_v.saturated, got.result_value, got.saturated);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (expected_results.size() == 0) begin
        note_mismatch("result beat with nothing pending", '0, res_o);
      end else begin
        want = expected_results.pop_front();
        if (res_o.result_value !== want.result_value || res_o.saturated !== want.saturated)
          note_mismatch("result mismatch", want, res_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[poly_basis_eval_with_derivs] ERROR");
      $finish;
    end
  end

  // Runs on the reset value of the basis select, so it also checks that it is Chebyshev.
  task automatic test_chebyshev_corners();
    idle_pct = 9;
    apply_point(mk_item('0, 0, FUNC_VALUE));
    apply_point(mk_item(X_ONE, 0, FUNC_D1));
    apply_point(mk_item(X_HALF, 1, FUNC_VALUE));
    apply_point(mk_item(X_HALF, 1, FUNC_D1));
    apply_point(mk_item(X_HALF, 1, FUNC_D2));
    apply_point(mk_item(X_ONE, 31, FUNC_VALUE));
    apply_point(mk_item(X_ONE, 31, FUNC_D1));
    apply_point(mk_item(X_ONE, 31, FUNC_D2));
    apply_point(mk_item(-X_ONE, 31, 2'd3));
    apply_point(mk_item(X_TOP, 31, FUNC_VALUE));
    apply_point(mk_item(X_BOT, 20, FUNC_D1));
    apply_point(mk_item(32'shFFFF_FFFF, 2, FUNC_VALUE));
  endtask

  task automatic test_monomial_corners();
    write_basis(BASIS_MONO);
    apply_point(mk_item('0, 0, FUNC_VALUE));
    apply_point(mk_item('0, 1, FUNC_D1));
    apply_point(mk_item('0, 2, FUNC_D2));
    apply_point(mk_item(X_ONE, 31, FUNC_D2));
    apply_point(mk_item(-X_ONE, 31, FUNC_D1));
    apply_point(mk_item(X_TOP, 31, FUNC_VALUE));
    apply_point(mk_item(X_BOT, 31, FUNC_VALUE));
    apply_point(mk_item(X_BOT, 17, FUNC_D2));
    apply_point(mk_item(X_HALF, 5, FUNC_VALUE));
    apply_point(mk_item(-X_HALF, 4, 2'd3));
    apply_point(mk_item(32'sh0000_0001, 3, FUNC_D1));
    apply_point(mk_item(32'sh2AAA_AAAA, 10, FUNC_VALUE));
  endtask

  task automatic test_random_points(int count, int gap_pct, logic kind);
    write_basis(kind);
    idle_pct = gap_pct;
    repeat (count) apply_point(random_item());
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 1'b0;
    basis_sel = BASIS_CHEB;
    idle_pct = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_chebyshev_corners();
    test_monomial_corners();
    test_random_points(270, 9, BASIS_CHEB);
    test_random_points(270, 9, BASIS_MONO);
    test_random_points(270, 54, BASIS_CHEB);
    test_random_points(270, 54, BASIS_MONO);
    test_random_points(260, 0, BASIS_MONO);
    test_random_points(260, 0, BASIS_CHEB);

    settle();
    repeat (70) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[poly_basis_eval_with_derivs] OK");
    end else begin
      $display("[poly_basis_eval_with_derivs] ERROR");
    end
    $finish;
  end
endmodule
